/* rtl/lsp_pkg.sv */
package lsp_pkg;

  localparam int NODE_W = 4;
  localparam int COST_W = 14;

  // cost that stands for a missing link or an unreachable node
  localparam logic [COST_W-1:0] NO_LINK = 14'd9999;

  typedef enum logic {
    OP_SET_LINK = 1'b0,
    OP_QUERY    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_AB,
    ST_WR_BA,
    ST_INIT,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_HOLD
  } state_t;

endpackage

/* rtl/lsp_if.sv */
interface lsp_in_if;
  import lsp_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [COST_W-1:0] link_cost;

  modport source (output valid, output opcode, output node_a, output node_b,
                  output link_cost, input ready);
  modport sink   (input valid, input opcode, input node_a, input node_b,
                  input link_cost, output ready);
endinterface

interface lsp_out_if;
  import lsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] dest_node;
  logic [COST_W-1:0] distance;
  logic              last;

  modport source (output valid, output dest_node, output distance, output last,
                  input ready);
  modport sink   (input valid, input dest_node, input distance, input last,
                  output ready);
endinterface

/* rtl/link_state_shortest_path.sv */
// channel | dir | transaction                          | fields
// --------+-----+--------------------------------------+------------------------------------
// in_ch   | in  | link update or shortest-path query   | opcode, node_a, node_b, link_cost
// out_ch  | out | one distance per destination, query  | dest_node, distance, last
//
// a link update is accepted, then writes one mirrored cell and then the other
// a query loads the source row, then runs at most NODES-1 relax passes, then
// reads out one result at a time; the cost memory has a single read port, so
// each pass reads its row one column at a time
// synchronous active-low reset; cost cells read as no link until first written
// one transaction in flight: in_ch.ready is low from accept until both cells are written
// or the last result leaves; results hold on out_ch while out_ch.ready is low
module link_state_shortest_path #(
  parameter int NODES = 4
) (
  input logic     clk,
  input logic     rst_n,
  lsp_in_if.sink  in_ch,
  lsp_out_if.source out_ch
);
  import lsp_pkg::*;

  localparam int IDX_W    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CM_AW    = 2 * IDX_W;
  localparam int CM_DEPTH = 1 << CM_AW;
  localparam int BD_DEPTH = 1 << IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  // control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;           // scan / output index
  logic               issue_done_r, issue_done_nxt;
  logic               p_vld_r, p_vld_nxt;       // read in flight to the memories
  logic [IDX_W-1:0]   iter_r, iter_nxt;         // relax passes started
  logic               found_r, found_nxt;
  logic [NODES-1:0]   visited_r, visited_nxt;
  logic [CM_DEPTH-1:0] cm_valid_r;

  // payload state
  logic [IDX_W-1:0]   p_idx_r, p_idx_nxt;
  logic               p_cmv_r, p_cmv_nxt;       // cost cell was written before
  logic [IDX_W-1:0]   src_r, src_nxt;
  logic [IDX_W-1:0]   m_r, m_nxt;               // node being settled
  logic [COST_W-1:0]  best_r, best_nxt;         // its distance
  logic [COST_W-1:0]  min_val_r, min_val_nxt;   // nearest unvisited so far
  logic [IDX_W-1:0]   min_idx_r, min_idx_nxt;
  logic [IDX_W-1:0]   upd_a_r, upd_a_nxt;
  logic [IDX_W-1:0]   upd_b_r, upd_b_nxt;
  logic [COST_W-1:0]  upd_cost_r, upd_cost_nxt;

  // memory ports
  logic               cm_we, cm_re;
  logic [CM_AW-1:0]   cm_waddr, cm_raddr;
  logic [COST_W-1:0]  cm_rdata;
  logic               bd_we, bd_re;
  logic [IDX_W-1:0]   bd_waddr, bd_raddr;
  logic [COST_W-1:0]  bd_wdata, bd_rdata;

  logic               in_acc, out_acc;
  logic               a_ok, b_ok;
  logic               scan_state, scan_end, pass_done;
  logic [COST_W-1:0]  link_cost_val;
  logic [COST_W:0]    relax_sum;
  logic [COST_W-1:0]  new_val;
  logic               new_cand;

  // link-cost matrix, row = from node, column = to node
  lsp_ram #(.WIDTH(COST_W), .DEPTH(CM_DEPTH)) u_cost_mem (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (upd_cost_r),
    .re    (cm_re),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  // tentative distances of the running query
  lsp_ram #(.WIDTH(COST_W), .DEPTH(BD_DEPTH)) u_dist_mem (
    .clk   (clk),
    .we    (bd_we),
    .waddr (bd_waddr),
    .wdata (bd_wdata),
    .re    (bd_re),
    .raddr (bd_raddr),
    .rdata (bd_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  assign a_ok = ({1'b0, in_ch.node_a} < (NODE_W + 1)'(NODES));
  assign b_ok = ({1'b0, in_ch.node_b} < (NODE_W + 1)'(NODES));

  assign scan_state = (state_r == ST_INIT) || (state_r == ST_RELAX);
  assign scan_end   = scan_state && issue_done_r && !p_vld_r;
  // stop when nothing reachable is left or all passes have run
  assign pass_done  = !found_r || (iter_r == LAST_IDX);

  // cost of the cell in the pipeline stage; unwritten cells mean no link
  assign link_cost_val = p_cmv_r ? cm_rdata : NO_LINK;
  assign relax_sum     = {1'b0, best_r} + {1'b0, link_cost_val};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == OP_SET_LINK) begin
            if (a_ok && b_ok) state_nxt = ST_WR_AB;
          end else if (a_ok) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_WR_AB: state_nxt = ST_WR_BA;
      ST_WR_BA: state_nxt = ST_IDLE;
      ST_INIT, ST_RELAX: begin
        if (scan_end) state_nxt = pass_done ? ST_OUT_RD : ST_RELAX;
      end
      ST_OUT_RD: state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (out_acc) state_nxt = (idx_r == LAST_IDX) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    p_vld_nxt      = 1'b0;
    iter_nxt       = iter_r;
    found_nxt      = found_r;
    visited_nxt    = visited_r;
    p_idx_nxt      = p_idx_r;
    p_cmv_nxt      = p_cmv_r;
    src_nxt        = src_r;
    m_nxt          = m_r;
    best_nxt       = best_r;
    min_val_nxt    = min_val_r;
    min_idx_nxt    = min_idx_r;
    upd_a_nxt      = upd_a_r;
    upd_b_nxt      = upd_b_r;
    upd_cost_nxt   = upd_cost_r;

    cm_we    = (state_r == ST_WR_AB) || (state_r == ST_WR_BA);
    cm_waddr = (state_r == ST_WR_AB) ? {upd_a_r, upd_b_r} : {upd_b_r, upd_a_r};
    cm_re    = scan_state && !issue_done_r;
    cm_raddr = {((state_r == ST_RELAX) ? m_r : src_r), idx_r};
    bd_re    = ((state_r == ST_RELAX) && !issue_done_r) || (state_r == ST_OUT_RD);
    bd_raddr = idx_r;
    bd_we    = 1'b0;
    bd_waddr = p_idx_r;
    bd_wdata = link_cost_val;
    new_val  = link_cost_val;
    new_cand = 1'b0;

    if (in_acc) begin
      upd_a_nxt    = in_ch.node_a[IDX_W-1:0];
      upd_b_nxt    = in_ch.node_b[IDX_W-1:0];
      // oversized costs saturate at no link
      upd_cost_nxt = (in_ch.link_cost > NO_LINK) ? NO_LINK : in_ch.link_cost;
      src_nxt        = in_ch.node_a[IDX_W-1:0];
      visited_nxt    = NODES'(1) << in_ch.node_a[IDX_W-1:0];
      idx_nxt        = '0;
      issue_done_nxt = 1'b0;
      min_val_nxt    = NO_LINK;
      found_nxt      = 1'b0;
      iter_nxt       = '0;
    end

    // issue one column per cycle
    if (cm_re) begin
      p_vld_nxt = 1'b1;
      p_idx_nxt = idx_r;
      p_cmv_nxt = cm_valid_r[cm_raddr];
      if (idx_r == LAST_IDX) issue_done_nxt = 1'b1;
      else idx_nxt = idx_r + 1'b1;
    end

    // data back from the memories
    if (p_vld_r) begin
      if (state_r == ST_INIT) begin
        bd_we   = 1'b1;
        new_val = link_cost_val;
        new_cand = !visited_r[p_idx_r];
      end else begin
        new_val = bd_rdata;
        if (!visited_r[p_idx_r]) begin
          new_cand = 1'b1;
          if (relax_sum < {1'b0, bd_rdata}) begin
            bd_we   = 1'b1;
            new_val = relax_sum[COST_W-1:0];
          end
        end
      end
      bd_wdata = new_val;
      // strict compare keeps the lowest index on ties
      if (new_cand && (new_val < min_val_r)) begin
        min_val_nxt = new_val;
        min_idx_nxt = p_idx_r;
        found_nxt   = 1'b1;
      end
    end

    if (scan_end) begin
      idx_nxt = '0;
      if (!pass_done) begin
        m_nxt          = min_idx_r;
        best_nxt       = min_val_r;
        visited_nxt    = visited_r | (NODES'(1) << min_idx_r);
        iter_nxt       = iter_r + 1'b1;
        issue_done_nxt = 1'b0;
        found_nxt      = 1'b0;
        min_val_nxt    = NO_LINK;
      end
    end

    if ((state_r == ST_OUT_HOLD) && out_acc && (idx_r != LAST_IDX)) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // result transaction straight from the registered memory read
  assign out_ch.valid     = (state_r == ST_OUT_HOLD);
  assign out_ch.dest_node = NODE_W'(idx_r);
  assign out_ch.distance  = bd_rdata;
  assign out_ch.last      = (idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      p_vld_r      <= 1'b0;
      iter_r       <= '0;
      found_r      <= 1'b0;
      visited_r    <= '0;
      cm_valid_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      p_vld_r      <= p_vld_nxt;
      iter_r       <= iter_nxt;
      found_r      <= found_nxt;
      visited_r    <= visited_nxt;
      if (cm_we) cm_valid_r[cm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r    <= p_idx_nxt;
    p_cmv_r    <= p_cmv_nxt;
    src_r      <= src_nxt;
    m_r        <= m_nxt;
    best_r     <= best_nxt;
    min_val_r  <= min_val_nxt;
    min_idx_r  <= min_idx_nxt;
    upd_a_r    <= upd_a_nxt;
    upd_b_r    <= upd_b_nxt;
    upd_cost_r <= upd_cost_nxt;
  end

endmodule

/* rtl/lsp_ram.sv */
module lsp_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* bench/link_state_shortest_path_tb.sv */
module link_state_shortest_path_tb;
  import lsp_pkg::*;

  localparam int NODES = 4;
  localparam int MAX_NODE = (1 << NODE_W) - 1;
  localparam int MAX_COST = (1 << COST_W) - 1;
  // random transactions after the directed rows, about 420 in all
  localparam int RANDOM_ITEMS = 395;
  // a query runs its load and relax passes plus receiver stalls between results, so this is far beyond any real gap
  localparam int IDLE_LIMIT = 2000;
  // an update or an ignored query may still be in flight once the last result is out
  localparam int DRAIN_CYCLES = 64;

  typedef logic [NODES-1:0][COST_W-1:0] dist_vec_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] link_cost;
  } link_txn_t;

  typedef struct packed {
    logic [NODE_W-1:0] dest_node;
    logic [COST_W-1:0] distance;
    logic              last;
  } route_t;

  // one row of the directed part; typed rows carry their distances by hand
  typedef struct packed {
    link_txn_t txn;
    logic      typed;
    dist_vec_t want_dist;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lsp_in_if  in_ch ();
  lsp_out_if out_ch ();

  link_state_shortest_path #(
    .NODES(NODES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the link-cost matrix, full 16x16 over every node number; the block stores only NODES x NODES
  logic [COST_W-1:0] link_cost_tab [0:MAX_NODE][0:MAX_NODE];
  route_t            expected_routes [$];
  dir_row_t          directed_rows [$];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                burst_left;
  int unsigned       rx_phase = 0;
  int unsigned       rx_mode = 0;
  int unsigned       rx_hold = 0;
  route_t            want_route;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // dense-matrix dijkstra from src: the source starts visited, so its own entry
  // stays at the diagonal cell; the search stops once nothing below no-link is left
  function automatic dist_vec_t shortest_reach(input int src);
    dist_vec_t         reach;
    logic [NODES-1:0]  visited;
    logic [COST_W-1:0] nearest;
    int                pick;
    int                sum;
    for (int j = 0; j < NODES; j++) reach[j] = link_cost_tab[src][j];
    visited = '0;
    visited[src] = 1'b1;
    for (int n = 1; n < NODES; n++) begin
      nearest = NO_LINK;
      pick = -1;
      // strict less-than keeps the lowest index on a tie
      for (int j = 0; j < NODES; j++) begin
        if (!visited[j] && reach[j] < nearest) begin
          nearest = reach[j];
          pick = j;
        end
      end
      if (pick < 0) break;
      visited[pick] = 1'b1;
      for (int k = 0; k < NODES; k++) begin
        if (!visited[k]) begin
          // sum may pass 9999, it only lands when it beats the current entry
          sum = int'(reach[pick]) + int'(link_cost_tab[pick][k]);
          if (sum < int'(reach[k])) reach[k] = sum[COST_W-1:0];
        end
      end
    end
    return reach;
  endfunction

  // applies one accepted transaction to the shadow matrix and queues its distances
  function automatic void commit_txn(input link_txn_t t, input logic typed,
                                     input dist_vec_t want);
    dist_vec_t         reach;
    logic [COST_W-1:0] c;
    route_t            r;
    if (t.opcode == OP_SET_LINK) begin
      // an endpoint outside the network leaves the matrix alone
      if (t.node_a < NODES && t.node_b < NODES) begin
        c = (t.link_cost > NO_LINK) ? NO_LINK : t.link_cost;
        link_cost_tab[t.node_a][t.node_b] = c;
        link_cost_tab[t.node_b][t.node_a] = c;
      end
    end else if (t.node_a < NODES) begin
      reach = typed ? want : shortest_reach(t.node_a);
      for (int j = 0; j < NODES; j++) begin
        r.dest_node = j[NODE_W-1:0];
        r.distance = reach[j];
        r.last = (j == NODES - 1);
        expected_routes.push_back(r);
      end
    end
  endfunction

  function automatic void add_row(input opcode_t op, input int a, input int b,
                                  input int cost, input logic typed, input dist_vec_t want);
    dir_row_t row;
    row.txn.opcode = op;
    row.txn.node_a = a[NODE_W-1:0];
    row.txn.node_b = b[NODE_W-1:0];
    row.txn.link_cost = cost[COST_W-1:0];
    row.typed = typed;
    row.want_dist = want;
    directed_rows.push_back(row);
  endfunction

  // mostly well-formed updates and queries with random content, some noise
  function automatic link_txn_t random_txn();
    link_txn_t t;
    int        r;
    int        k;
    r = $urandom_range(0, 99);
    t.node_b = NODE_W'($urandom_range(0, MAX_NODE));
    t.link_cost = COST_W'($urandom_range(0, MAX_COST));
    if (r < 45) begin
      t.opcode = OP_SET_LINK;
      t.node_a = NODE_W'($urandom_range(0, NODES - 1));
      t.node_b = NODE_W'($urandom_range(0, NODES - 1));
      // small costs build real paths, no-link and near-limit costs cut them
      k = $urandom_range(0, 99);
      if (k < 55) t.link_cost = COST_W'($urandom_range(0, 15));
      else if (k < 70) t.link_cost = NO_LINK;
      else if (k < 80) t.link_cost = COST_W'($urandom_range(9000, 9999));
      else if (k < 88) t.link_cost = COST_W'($urandom_range(10000, MAX_COST));
    end else if (r < 55) begin
      // update with one endpoint off the network
      t.opcode = OP_SET_LINK;
      t.node_a = NODE_W'($urandom_range(NODES, MAX_NODE));
      if ($urandom_range(0, 1) == 1) begin
        t.node_a = t.node_b;
        t.node_b = NODE_W'($urandom_range(NODES, MAX_NODE));
      end
    end else if (r < 92) begin
      t.opcode = OP_QUERY;
      t.node_a = NODE_W'($urandom_range(0, NODES - 1));
    end else begin
      t.opcode = OP_QUERY;
      t.node_a = NODE_W'($urandom_range(NODES, MAX_NODE));
    end
    return t;
  endfunction

  // drive at the falling edge, hold until the block takes the transaction
  task automatic send_txn(input link_txn_t t);
    in_ch.valid = 1'b1;
    in_ch.opcode = t.opcode;
    in_ch.node_a = t.node_a;
    in_ch.node_b = t.node_b;
    in_ch.link_cost = t.link_cost;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // bursts of back-to-back transactions, now and then a long one, with gaps between
  task automatic pace_sender();
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // receiver: rx_phase steps the mode among always ready, coin flips,
  // one in five, and long stalls of random length
  always @(negedge clk) begin
    if (rx_phase % 128 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 1) == 1);
      2: out_ch.ready = (rx_phase % 5 == 0);
      default: begin
        if (rx_hold == 0) begin
          out_ch.ready = 1'b1;
          rx_hold = $urandom_range(1, 12);
        end else begin
          out_ch.ready = 1'b0;
          rx_hold--;
        end
      end
    endcase
    rx_phase++;
  end

  // result check: each transaction on out_ch against the oldest queued distance
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_routes.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: dest %0d distance %0d last %0b", $time,
                 out_ch.dest_node, out_ch.distance, out_ch.last);
      end else begin
        want_route = expected_routes.pop_front();
        if (out_ch.dest_node !== want_route.dest_node ||
            out_ch.distance !== want_route.distance || out_ch.last !== want_route.last) begin
          mismatch_count++;
          $display("%0t mismatch: expected dest %0d distance %0d last %0b, got dest %0d distance %0d last %0b",
                   $time, want_route.dest_node, want_route.distance, want_route.last,
                   out_ch.dest_node, out_ch.distance, out_ch.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout, %0d results still expected", $time, expected_routes.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    link_txn_t t;
    dir_row_t  row;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_SET_LINK;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    in_ch.link_cost = '0;
    burst_left = 0;
    foreach (link_cost_tab[i, j]) link_cost_tab[i][j] = NO_LINK;

    // after reset every cell is no link, the diagonal too
    add_row(OP_QUERY, 0, 0, 0, 1'b1, {NODES{NO_LINK}});
    add_row(OP_QUERY, NODES - 1, 0, 0, 1'b1, {NODES{NO_LINK}});
    // sources off the network give nothing
    add_row(OP_QUERY, NODES, 0, 0, 1'b1, '0);
    add_row(OP_QUERY, MAX_NODE, MAX_NODE, MAX_COST, 1'b1, '0);
    // diagonal cell becomes the source's own distance
    add_row(OP_SET_LINK, 0, 0, 7, 1'b0, '0);
    add_row(OP_QUERY, 0, 0, 0, 1'b1, {NO_LINK, NO_LINK, NO_LINK, 14'd7});
    // oversized cost is stored as no link
    add_row(OP_SET_LINK, 2, 3, MAX_COST, 1'b0, '0);
    add_row(OP_SET_LINK, 1, 2, 0, 1'b0, '0);
    // endpoints off the network change nothing
    add_row(OP_SET_LINK, NODES, 1, 5, 1'b0, '0);
    add_row(OP_SET_LINK, 1, MAX_NODE, 5, 1'b0, '0);
    add_row(OP_QUERY, 1, 0, 0, 1'b1, {NO_LINK, 14'd0, NO_LINK, NO_LINK});
    // largest real cost: a path through it overshoots no link and must not land
    add_row(OP_SET_LINK, 2, 3, 9998, 1'b0, '0);
    add_row(OP_SET_LINK, 0, 3, 4, 1'b0, '0);
    add_row(OP_QUERY, 0, 0, 0, 1'b0, '0);
    add_row(OP_SET_LINK, 0, 1, 2, 1'b0, '0);
    add_row(OP_SET_LINK, 2, 3, 1, 1'b0, '0);
    add_row(OP_QUERY, 3, 0, 0, 1'b0, '0);
    // equal-cost candidates from node 1
    add_row(OP_SET_LINK, 1, 3, 2, 1'b0, '0);
    add_row(OP_SET_LINK, 0, 2, 3, 1'b0, '0);
    add_row(OP_QUERY, 1, 0, 0, 1'b0, '0);
    // link removed again
    add_row(OP_SET_LINK, 0, 1, NO_LINK, 1'b0, '0);
    add_row(OP_QUERY, 2, 0, 0, 1'b0, '0);
    // query with noise in the fields it ignores
    add_row(OP_QUERY, NODES - 1, MAX_NODE, MAX_COST, 1'b0, '0);
    add_row(OP_SET_LINK, 3, 3, 0, 1'b0, '0);
    add_row(OP_QUERY, 3, 0, 0, 1'b0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_txn(row.txn);
      commit_txn(row.txn, row.typed, row.want_dist);
      pace_sender();
    end

    // ignored transactions are sent and counted like any other
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      t = random_txn();
      send_txn(t);
      commit_txn(t, 1'b0, '0);
      pace_sender();
    end
    in_ch.valid = 1'b0;

    while (expected_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_routes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
